// File: rtl/core/spbm_pkg.sv
// Shared constants for the switchable PRG bank mapper: bus decode bounds,
// command and source codes, register indexes, memory sizes and widths.
// No dependencies.
package spbm_pkg;

    // Internal RAM sizes in bytes
    localparam int unsigned PRG_RAM_BYTES = 8192;
    localparam int unsigned CHR_RAM_BYTES = 8192;
    localparam int unsigned PRG_RAM_AW    = $clog2(PRG_RAM_BYTES);
    localparam int unsigned CHR_RAM_AW    = $clog2(CHR_RAM_BYTES);

    // Field widths
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned DATA_W  = 8;
    localparam int unsigned ROMA_W  = 22;
    localparam int unsigned SRC_W   = 3;
    localparam int unsigned CFGI_W  = 2;
    localparam int unsigned CFGD_W  = 23;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned PRGSZ_W = 23;
    localparam int unsigned CHRSZ_W = 14;
    localparam int unsigned BANK_W  = 8;
    localparam int unsigned BANK_OFS_W = 14;   // 16 KiB window offset

    // Remainder unit: widest dividend is {bank, window offset}
    localparam int unsigned DIV_W   = COUNT_W + BANK_OFS_W;
    localparam int unsigned DIV_CW  = $clog2(DIV_W);

    // Bus commands
    localparam logic [CMD_W-1:0] CMD_CPU_RD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CPU_WR = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PPU_RD = 2'd2;
    localparam logic [CMD_W-1:0] CMD_PPU_WR = 2'd3;

    // Result sources
    localparam logic [SRC_W-1:0] SRC_NONE    = 3'd0;
    localparam logic [SRC_W-1:0] SRC_PRG_ROM = 3'd1;
    localparam logic [SRC_W-1:0] SRC_CHR_ROM = 3'd2;
    localparam logic [SRC_W-1:0] SRC_PRG_RAM = 3'd3;
    localparam logic [SRC_W-1:0] SRC_CHR_RAM = 3'd4;

    // Register indexes
    localparam logic [CFGI_W-1:0] CFG_PRG_BANK_COUNT = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_PRG_ROM_BYTES  = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_CHR_IS_RAM     = 2'd2;
    localparam logic [CFGI_W-1:0] CFG_CHR_ROM_BYTES  = 2'd3;

    // Register reset values
    localparam logic [COUNT_W-1:0] RST_PRG_BANK_COUNT = 9'd1;
    localparam logic [PRGSZ_W-1:0] RST_PRG_ROM_BYTES  = 23'd16384;
    localparam logic [CHRSZ_W-1:0] RST_CHR_ROM_BYTES  = 14'd8192;

    // Address map
    localparam logic [ADDR_W-1:0] CPU_ROM_BASE   = 16'h8000;
    localparam logic [ADDR_W-1:0] CPU_FIXED_BASE = 16'hC000;
    localparam logic [ADDR_W-1:0] CPU_RAM_BASE   = 16'h6000;
    localparam logic [ADDR_W-1:0] PPU_PAT_END    = 16'h2000;

endpackage

// File: rtl/core/spbm_ram.sv
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing; used for both internal mapper memories.
module spbm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/switchable_prg_bank_mapper.sv
// Top level of the switchable PRG bank mapper (UxROM style).
// Depends on spbm_pkg and spbm_ram.
//
// Input channel (i_in_valid / o_in_ready) takes one bus access word: command,
// bus address, write data. Reads return one word on the output channel
// (o_out_valid / i_out_ready): read data, ROM byte address, source; writes
// return nothing. Configuration channel (i_cfg_valid / o_cfg_ready) is always
// ready; write registers only while the block is idle.
// Sequencing, one word at a time: PRG ROM reads, CHR ROM reads and bank selects
// run a 23-step restoring remainder unit, one quotient bit per cycle, then the
// access state. RAM accesses index directly and go straight to the access
// state. Reads then pass the result stage; unmapped reads go to it directly.
// Writes and bank selects return to idle from the access state; ignored
// writes leave the block idle.
// Reset: registers go to their reset values, the bank select to 0. Both 8 KiB
// RAMs are then cleared one entry a cycle; no input word is taken during the
// clear (configuration writes still are).
// Stall: a finished result sits in the output register; the next word is taken
// meanwhile and its result waits in the result stage until the register frees.
module switchable_prg_bank_mapper (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input words
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [spbm_pkg::CMD_W-1:0]          i_command,
    input  logic [spbm_pkg::ADDR_W-1:0]         i_bus_address,
    input  logic [spbm_pkg::DATA_W-1:0]         i_write_data,
    // result words
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [spbm_pkg::DATA_W-1:0]         o_read_data,
    output logic [spbm_pkg::ROMA_W-1:0]         o_rom_address,
    output logic [spbm_pkg::SRC_W-1:0]          o_data_source,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [spbm_pkg::CFGI_W-1:0]         i_cfg_index,
    input  logic [spbm_pkg::CFGD_W-1:0]         i_cfg_data
);

    localparam int unsigned DIV_W = spbm_pkg::DIV_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_ACCESS,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE_RD,
        OP_IGNORE,
        OP_PRG_ROM,
        OP_CHR_ROM,
        OP_PRG_RAM_RD,
        OP_PRG_RAM_WR,
        OP_CHR_RAM_RD,
        OP_CHR_RAM_WR,
        OP_BANK_WR
    } t_op;

    // configuration registers
    logic [spbm_pkg::COUNT_W-1:0]  r_prg_bank_count;
    logic [spbm_pkg::PRGSZ_W-1:0]  r_prg_rom_bytes;
    logic                          r_chr_is_ram;
    logic [spbm_pkg::CHRSZ_W-1:0]  r_chr_rom_bytes;

    // control and per-word state
    t_state                         r_state;
    t_op                            r_op;
    logic [spbm_pkg::BANK_W-1:0]    r_bank;
    logic [spbm_pkg::CHR_RAM_AW-1:0] r_clr;
    logic [spbm_pkg::DATA_W-1:0]    r_wdata;

    // remainder unit
    logic [DIV_W-1:0]               r_dividend;
    logic [DIV_W-1:0]               r_divisor;
    logic [DIV_W-1:0]               r_rem;
    logic [spbm_pkg::DIV_CW-1:0]    r_step;
    logic [DIV_W:0]                 div_trial;
    logic [DIV_W:0]                 div_diff;
    logic [DIV_W-1:0]               n_rem;
    logic [DIV_W-1:0]               rem_final;

    // output register
    logic                           r_out_valid;
    logic [spbm_pkg::DATA_W-1:0]    r_read_data;
    logic [spbm_pkg::ROMA_W-1:0]    r_rom_address;
    logic [spbm_pkg::SRC_W-1:0]     r_data_source;
    logic                           out_load;

    // accept-side decode
    logic                           in_fire;
    t_op                            dec_op;
    logic [DIV_W-1:0]               dec_dividend;
    logic [DIV_W-1:0]               dec_divisor;
    logic [spbm_pkg::COUNT_W-1:0]   fixed_bank;
    logic [spbm_pkg::COUNT_W-1:0]   win_bank;
    logic [spbm_pkg::ADDR_W-1:0]    ram_ofs;

    // memory ports
    logic                                prg_we, prg_re, chr_we, chr_re;
    logic [spbm_pkg::PRG_RAM_AW-1:0]     prg_addr;
    logic [spbm_pkg::CHR_RAM_AW-1:0]     chr_addr;
    logic [spbm_pkg::DATA_W-1:0]         prg_wdata, chr_wdata, prg_rdata, chr_rdata;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;

    // result stage hands over when the output register is empty or draining
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // last bank sits in the upper window; zero count maps it to bank 0
    assign fixed_bank = (r_prg_bank_count != '0) ?
                        r_prg_bank_count - spbm_pkg::COUNT_W'(1) : '0;
    assign ram_ofs    = i_bus_address - spbm_pkg::CPU_RAM_BASE;

    always_comb begin
        dec_op       = OP_IGNORE;
        dec_dividend = '0;
        dec_divisor  = '0;
        win_bank     = (i_bus_address >= spbm_pkg::CPU_FIXED_BASE) ? fixed_bank :
                       spbm_pkg::COUNT_W'(r_bank);
        case (i_command)
            spbm_pkg::CMD_CPU_RD: begin
                if (i_bus_address >= spbm_pkg::CPU_ROM_BASE) begin
                    dec_op       = OP_PRG_ROM;
                    dec_dividend = {win_bank, i_bus_address[spbm_pkg::BANK_OFS_W-1:0]};
                    dec_divisor  = DIV_W'(r_prg_rom_bytes);
                end else if (i_bus_address >= spbm_pkg::CPU_RAM_BASE) begin
                    dec_op = OP_PRG_RAM_RD;
                end else begin
                    dec_op = OP_NONE_RD;
                end
            end
            spbm_pkg::CMD_CPU_WR: begin
                if (i_bus_address >= spbm_pkg::CPU_ROM_BASE) begin
                    dec_op       = OP_BANK_WR;
                    dec_dividend = DIV_W'(i_write_data);
                    dec_divisor  = DIV_W'(r_prg_bank_count);
                end else if (i_bus_address >= spbm_pkg::CPU_RAM_BASE) begin
                    dec_op = OP_PRG_RAM_WR;
                end
            end
            spbm_pkg::CMD_PPU_RD: begin
                if (i_bus_address >= spbm_pkg::PPU_PAT_END) begin
                    dec_op = OP_NONE_RD;
                end else if (r_chr_is_ram) begin
                    dec_op = OP_CHR_RAM_RD;
                end else begin
                    dec_op       = OP_CHR_ROM;
                    dec_dividend = DIV_W'(i_bus_address);
                    dec_divisor  = DIV_W'(r_chr_rom_bytes);
                end
            end
            spbm_pkg::CMD_PPU_WR: begin
                if (i_bus_address < spbm_pkg::PPU_PAT_END && r_chr_is_ram) begin
                    dec_op = OP_CHR_RAM_WR;
                end
            end
            default: dec_op = OP_IGNORE;
        endcase
    end

    // one restoring step per cycle; remainder stays below a nonzero divisor
    assign div_trial = {r_rem, r_dividend[DIV_W-1]};
    assign div_diff  = div_trial - {1'b0, r_divisor};
    assign n_rem     = div_diff[DIV_W] ? div_trial[DIV_W-1:0] : div_diff[DIV_W-1:0];
    // modulo by zero gives zero
    assign rem_final = (r_divisor == '0) ? '0 : r_rem;

    // memory port control
    always_comb begin
        prg_we    = 1'b0;
        prg_re    = 1'b0;
        chr_we    = 1'b0;
        chr_re    = 1'b0;
        prg_addr  = r_rem[spbm_pkg::PRG_RAM_AW-1:0];
        chr_addr  = r_rem[spbm_pkg::CHR_RAM_AW-1:0];
        prg_wdata = r_wdata;
        chr_wdata = r_wdata;
        if (r_state == S_CLEAR) begin
            prg_we    = 1'b1;
            chr_we    = 1'b1;
            prg_addr  = r_clr[spbm_pkg::PRG_RAM_AW-1:0];
            chr_addr  = r_clr;
            prg_wdata = '0;
            chr_wdata = '0;
        end else if (r_state == S_ACCESS) begin
            prg_we = (r_op == OP_PRG_RAM_WR);
            prg_re = (r_op == OP_PRG_RAM_RD);
            chr_we = (r_op == OP_CHR_RAM_WR);
            chr_re = (r_op == OP_CHR_RAM_RD);
        end
    end

    spbm_ram #(
        .WIDTH (spbm_pkg::DATA_W),
        .DEPTH (spbm_pkg::PRG_RAM_BYTES)
    ) u_prg_ram (
        .i_clk   (i_clk),
        .i_we    (prg_we),
        .i_re    (prg_re),
        .i_addr  (prg_addr),
        .i_wdata (prg_wdata),
        .o_rdata (prg_rdata)
    );

    spbm_ram #(
        .WIDTH (spbm_pkg::DATA_W),
        .DEPTH (spbm_pkg::CHR_RAM_BYTES)
    ) u_chr_ram (
        .i_clk   (i_clk),
        .i_we    (chr_we),
        .i_re    (chr_re),
        .i_addr  (chr_addr),
        .i_wdata (chr_wdata),
        .o_rdata (chr_rdata)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_bank_count <= spbm_pkg::RST_PRG_BANK_COUNT;
            r_prg_rom_bytes  <= spbm_pkg::RST_PRG_ROM_BYTES;
            r_chr_is_ram     <= 1'b1;
            r_chr_rom_bytes  <= spbm_pkg::RST_CHR_ROM_BYTES;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                spbm_pkg::CFG_PRG_BANK_COUNT:
                    r_prg_bank_count <= i_cfg_data[spbm_pkg::COUNT_W-1:0];
                spbm_pkg::CFG_PRG_ROM_BYTES:
                    r_prg_rom_bytes  <= i_cfg_data[spbm_pkg::PRGSZ_W-1:0];
                spbm_pkg::CFG_CHR_IS_RAM:
                    r_chr_is_ram     <= i_cfg_data[0];
                spbm_pkg::CFG_CHR_ROM_BYTES:
                    r_chr_rom_bytes  <= i_cfg_data[spbm_pkg::CHRSZ_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer, remainder unit and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_op        <= OP_IGNORE;
            r_bank      <= '0;
            r_clr       <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + spbm_pkg::CHR_RAM_AW'(1);
                    if (r_clr == spbm_pkg::CHR_RAM_AW'(spbm_pkg::CHR_RAM_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_fire) begin
                        r_op       <= dec_op;
                        r_wdata    <= i_write_data;
                        r_dividend <= dec_dividend;
                        r_divisor  <= dec_divisor;
                        r_step     <= '0;
                        case (dec_op)
                            // pattern RAM index is the address itself
                            OP_CHR_RAM_RD, OP_CHR_RAM_WR:
                                r_rem <= DIV_W'(i_bus_address[spbm_pkg::CHR_RAM_AW-1:0]);
                            // program RAM size is a power of two: the mask mirrors it
                            OP_PRG_RAM_RD, OP_PRG_RAM_WR:
                                r_rem <= DIV_W'(ram_ofs[spbm_pkg::PRG_RAM_AW-1:0]);
                            default: r_rem <= '0;
                        endcase
                        case (dec_op)
                            OP_IGNORE:                    r_state <= S_IDLE;
                            OP_NONE_RD:                   r_state <= S_DONE;
                            OP_CHR_RAM_RD, OP_CHR_RAM_WR,
                            OP_PRG_RAM_RD, OP_PRG_RAM_WR: r_state <= S_ACCESS;
                            default:                      r_state <= S_DIV;
                        endcase
                    end
                end
                S_DIV: begin
                    r_rem      <= n_rem;
                    r_dividend <= {r_dividend[DIV_W-2:0], 1'b0};
                    r_step     <= r_step + spbm_pkg::DIV_CW'(1);
                    if (r_step == spbm_pkg::DIV_CW'(DIV_W - 1)) begin
                        r_state <= S_ACCESS;
                    end
                end
                S_ACCESS: begin
                    case (r_op)
                        OP_BANK_WR: begin
                            r_bank  <= rem_final[spbm_pkg::BANK_W-1:0];
                            r_state <= S_IDLE;
                        end
                        OP_PRG_RAM_WR, OP_CHR_RAM_WR: r_state <= S_IDLE;
                        default:                      r_state <= S_DONE;
                    endcase
                end
                S_DONE: begin
                    if (out_load) begin
                        r_read_data   <= '0;
                        r_rom_address <= '0;
                        r_state       <= S_IDLE;
                        case (r_op)
                            OP_PRG_ROM: begin
                                r_data_source <= spbm_pkg::SRC_PRG_ROM;
                                r_rom_address <= rem_final[spbm_pkg::ROMA_W-1:0];
                            end
                            OP_CHR_ROM: begin
                                r_data_source <= spbm_pkg::SRC_CHR_ROM;
                                r_rom_address <= rem_final[spbm_pkg::ROMA_W-1:0];
                            end
                            OP_PRG_RAM_RD: begin
                                r_data_source <= spbm_pkg::SRC_PRG_RAM;
                                r_read_data   <= prg_rdata;
                            end
                            OP_CHR_RAM_RD: begin
                                r_data_source <= spbm_pkg::SRC_CHR_RAM;
                                r_read_data   <= chr_rdata;
                            end
                            default: r_data_source <= spbm_pkg::SRC_NONE;
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_read_data;
    assign o_rom_address = r_rom_address;
    assign o_data_source = r_data_source;

    // remainder never reaches a nonzero divisor while stepping
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_divisor != '0) |-> (r_rem < r_divisor))
        else $error("remainder not below divisor");

    // a RAM read is always followed by the result stage
    a_read_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (prg_re || chr_re) |=> (r_state == S_DONE))
        else $error("RAM read not followed by result stage");

    // a new result appears only out of the result stage
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result loaded outside result stage");

    // no RAM is read and written in the same cycle
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((prg_we && prg_re) || (chr_we && chr_re)))
        else $error("RAM read and write overlap");

endmodule

// File: verif/mapper_check.sv
// Checker for the switchable PRG bank mapper: watches the input, result and
// register channels, predicts each read word and compares it field by field.
// Depends on spbm_pkg.
module mapper_check (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [spbm_pkg::CMD_W-1:0]    i_command,
    input  logic [spbm_pkg::ADDR_W-1:0]   i_bus_address,
    input  logic [spbm_pkg::DATA_W-1:0]   i_write_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [spbm_pkg::DATA_W-1:0]   i_read_data,
    input  logic [spbm_pkg::ROMA_W-1:0]   i_rom_address,
    input  logic [spbm_pkg::SRC_W-1:0]    i_data_source,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [spbm_pkg::CFGI_W-1:0]   i_cfg_index,
    input  logic [spbm_pkg::CFGD_W-1:0]   i_cfg_data,
    output int                            o_mismatches,
    output int                            o_reads_owed
);

    typedef struct packed {
        logic [spbm_pkg::DATA_W-1:0] data;
        logic [spbm_pkg::ROMA_W-1:0] rom;
        logic [spbm_pkg::SRC_W-1:0]  src;
    } t_read_word;

    // shadow registers and memories
    logic [spbm_pkg::COUNT_W-1:0] bank_count;
    logic [spbm_pkg::PRGSZ_W-1:0] prg_bytes;
    logic                         chr_ram_mode;
    logic [spbm_pkg::CHRSZ_W-1:0] chr_bytes;
    logic [spbm_pkg::BANK_W-1:0]  low_bank;
    logic [spbm_pkg::DATA_W-1:0]  prg_ram [spbm_pkg::PRG_RAM_BYTES];
    logic [spbm_pkg::DATA_W-1:0]  chr_ram [spbm_pkg::CHR_RAM_BYTES];

    t_read_word reads_owed [$];
    int         mismatches = 0;

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatches++;
        if (mismatches <= 100) begin
            $display("%0t: mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        end
    endtask

    // One bus access: updates the shadow state, returns the read word if any.
    task automatic map_access(input logic [spbm_pkg::CMD_W-1:0] cmd,
                              input logic [spbm_pkg::ADDR_W-1:0] addr,
                              input logic [spbm_pkg::DATA_W-1:0] wdata, output bit is_read,
                              output t_read_word word);
        longint unsigned bank;
        longint unsigned ofs;
        word    = '0;
        is_read = (cmd == spbm_pkg::CMD_CPU_RD) || (cmd == spbm_pkg::CMD_PPU_RD);
        case (cmd)
            spbm_pkg::CMD_CPU_RD: begin
                if (addr >= spbm_pkg::CPU_ROM_BASE) begin
                    if (addr < spbm_pkg::CPU_FIXED_BASE) begin
                        bank = low_bank;
                    end else begin
                        bank = (bank_count != 0) ? bank_count - 1 : 0;
                    end
                    ofs = longint'(addr & 16'h3FFF) + bank * 64'h4000;
                    ofs = (prg_bytes != 0) ? ofs % prg_bytes : 0;
                    word.rom = ofs[spbm_pkg::ROMA_W-1:0];
                    word.src = spbm_pkg::SRC_PRG_ROM;
                end else if (addr >= spbm_pkg::CPU_RAM_BASE) begin
                    word.data = prg_ram[(addr - spbm_pkg::CPU_RAM_BASE) %
                                        spbm_pkg::PRG_RAM_BYTES];
                    word.src  = spbm_pkg::SRC_PRG_RAM;
                end else begin
                    word.src = spbm_pkg::SRC_NONE;
                end
            end
            spbm_pkg::CMD_CPU_WR: begin
                if (addr >= spbm_pkg::CPU_ROM_BASE) begin
                    low_bank = (bank_count != 0) ?
                               spbm_pkg::BANK_W'(wdata % bank_count) : '0;
                end else if (addr >= spbm_pkg::CPU_RAM_BASE) begin
                    prg_ram[(addr - spbm_pkg::CPU_RAM_BASE) % spbm_pkg::PRG_RAM_BYTES] = wdata;
                end
            end
            spbm_pkg::CMD_PPU_RD: begin
                if (addr < spbm_pkg::PPU_PAT_END) begin
                    if (chr_ram_mode) begin
                        word.data = chr_ram[addr % spbm_pkg::CHR_RAM_BYTES];
                        word.src  = spbm_pkg::SRC_CHR_RAM;
                    end else begin
                        word.rom = (chr_bytes != 0) ?
                                   spbm_pkg::ROMA_W'(addr % chr_bytes) : '0;
                        word.src = spbm_pkg::SRC_CHR_ROM;
                    end
                end else begin
                    word.src = spbm_pkg::SRC_NONE;
                end
            end
            default: begin
                if (addr < spbm_pkg::PPU_PAT_END && chr_ram_mode) begin
                    chr_ram[addr % spbm_pkg::CHR_RAM_BYTES] = wdata;
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_read_word want;
        bit         is_read;
        if (!i_rst_n) begin
            bank_count   = spbm_pkg::RST_PRG_BANK_COUNT;
            prg_bytes    = spbm_pkg::RST_PRG_ROM_BYTES;
            chr_ram_mode = 1'b1;
            chr_bytes    = spbm_pkg::RST_CHR_ROM_BYTES;
            low_bank     = '0;
            for (int k = 0; k < spbm_pkg::PRG_RAM_BYTES; k++) prg_ram[k] = '0;
            for (int k = 0; k < spbm_pkg::CHR_RAM_BYTES; k++) chr_ram[k] = '0;
            reads_owed.delete();
        end else begin
            // result first: it always belongs to an earlier word
            if (i_out_valid && i_out_ready) begin
                if (reads_owed.size() == 0) begin
                    report_mismatch("result word with no read pending",
                                    {i_read_data, i_rom_address, i_data_source}, 0);
                end else begin
                    want = reads_owed.pop_front();
                    if (i_read_data !== want.data)
                        report_mismatch("read_data", i_read_data, want.data);
                    if (i_rom_address !== want.rom)
                        report_mismatch("rom_address", i_rom_address, want.rom);
                    if (i_data_source !== want.src)
                        report_mismatch("data_source", i_data_source, want.src);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    spbm_pkg::CFG_PRG_BANK_COUNT:
                        bank_count   = i_cfg_data[spbm_pkg::COUNT_W-1:0];
                    spbm_pkg::CFG_PRG_ROM_BYTES:
                        prg_bytes    = i_cfg_data[spbm_pkg::PRGSZ_W-1:0];
                    spbm_pkg::CFG_CHR_IS_RAM:
                        chr_ram_mode = i_cfg_data[0];
                    spbm_pkg::CFG_CHR_ROM_BYTES:
                        chr_bytes    = i_cfg_data[spbm_pkg::CHRSZ_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                map_access(i_command, i_bus_address, i_write_data, is_read, want);
                if (is_read) reads_owed.push_back(want);
            end
        end
        o_mismatches <= mismatches;
        o_reads_owed <= reads_owed.size();
    end

endmodule

// File: verif/testbench.sv
// Regression top for the switchable PRG bank mapper: drives access words and
// register writes with random gaps and stalls, verdict from mapper_check.
// Depends on spbm_pkg, switchable_prg_bank_mapper and mapper_check.
module testbench;

    localparam int CLK_HALF         = 5;
    localparam int RANDOM_PER_PHASE = 175;   // ~1400 random words over 8 phases
    localparam int N_PHASES         = 8;
    localparam int DRAIN_CYCLES     = 40;
    // slowest run: the RAM clear plus ~1425 words, each with a full busy time,
    // gap and stall, taken several times over
    localparam int CYCLE_LIMIT      = 800000;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    logic [spbm_pkg::CMD_W-1:0]   command   = spbm_pkg::CMD_CPU_RD;
    logic [spbm_pkg::ADDR_W-1:0]  bus_addr  = '0;
    logic [spbm_pkg::DATA_W-1:0]  wr_data   = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b1;
    logic [spbm_pkg::DATA_W-1:0]  rd_data;
    logic [spbm_pkg::ROMA_W-1:0]  rom_addr;
    logic [spbm_pkg::SRC_W-1:0]   data_src;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [spbm_pkg::CFGI_W-1:0]  cfg_index = spbm_pkg::CFG_PRG_BANK_COUNT;
    logic [spbm_pkg::CFGD_W-1:0]  cfg_data  = '0;

    int mismatches;
    int reads_owed;
    int cycles = 0;

    // per-phase idling switches, so some stretches run with no gaps at all
    bit in_gaps_on    = 1'b0;
    bit out_stalls_on = 1'b0;
    int ready_hold    = 0;

    switchable_prg_bank_mapper uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_command     (command),
        .i_bus_address (bus_addr),
        .i_write_data  (wr_data),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_read_data   (rd_data),
        .o_rom_address (rom_addr),
        .o_data_source (data_src),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    mapper_check u_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_command     (command),
        .i_bus_address (bus_addr),
        .i_write_data  (wr_data),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_read_data   (rd_data),
        .i_rom_address (rom_addr),
        .i_data_source (data_src),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_mismatches  (mismatches),
        .o_reads_owed  (reads_owed)
    );

    always #(CLK_HALF) clk = ~clk;

    // watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // mostly short idles, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure: hold a random ready level for a random span
    always @(posedge clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (!out_stalls_on) begin
            out_ready <= 1'b1;
        end else begin
            out_ready  <= ($urandom_range(0, 2) != 0);
            ready_hold <= idle_len();
        end
    end

    // Present one access word and hold it until taken. Called at a clock edge;
    // with no gap valid simply stays high into the next word.
    task automatic send_access(input logic [spbm_pkg::CMD_W-1:0] cmd,
                               input logic [spbm_pkg::ADDR_W-1:0] addr,
                               input logic [spbm_pkg::DATA_W-1:0] data);
        int unsigned gap;
        gap = in_gaps_on ? idle_len() : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        command  <= cmd;
        bus_addr <= addr;
        wr_data  <= data;
        do @(posedge clk); while (!in_ready);
    endtask

    // Random word: addresses lean toward the mapped windows, and half the RAM
    // traffic hits a small pool so reads find bytes written earlier.
    task automatic send_random();
        logic [spbm_pkg::CMD_W-1:0]  cmd;
        logic [spbm_pkg::ADDR_W-1:0] addr;
        int unsigned                 pick;
        cmd  = spbm_pkg::CMD_W'($urandom_range(0, 3));
        pick = $urandom_range(0, 9);
        if (cmd == spbm_pkg::CMD_CPU_RD || cmd == spbm_pkg::CMD_CPU_WR) begin
            if (pick == 0) begin
                addr = spbm_pkg::ADDR_W'($urandom_range(0, 16'hFFFF));
            end else if (pick == 1) begin
                addr = spbm_pkg::ADDR_W'($urandom_range(0, spbm_pkg::CPU_RAM_BASE - 1));
            end else if (pick <= 4) begin
                if ($urandom_range(0, 1) != 0)
                    addr = spbm_pkg::ADDR_W'(spbm_pkg::CPU_RAM_BASE + $urandom_range(0, 15));
                else
                    addr = spbm_pkg::ADDR_W'($urandom_range(spbm_pkg::CPU_RAM_BASE,
                                                            spbm_pkg::CPU_ROM_BASE - 1));
            end else if (pick <= 7) begin
                // writes here are bank selects
                addr = spbm_pkg::ADDR_W'($urandom_range(spbm_pkg::CPU_ROM_BASE,
                                                        spbm_pkg::CPU_FIXED_BASE - 1));
            end else begin
                addr = spbm_pkg::ADDR_W'($urandom_range(spbm_pkg::CPU_FIXED_BASE, 16'hFFFF));
            end
        end else begin
            if (pick <= 1) begin
                addr = spbm_pkg::ADDR_W'($urandom_range(0, 16'hFFFF));
            end else if (pick <= 5) begin
                addr = spbm_pkg::ADDR_W'($urandom_range(0, 15));
            end else begin
                addr = spbm_pkg::ADDR_W'($urandom_range(0, spbm_pkg::PPU_PAT_END - 1));
            end
        end
        send_access(cmd, addr, spbm_pkg::DATA_W'($urandom_range(0, 255)));
    endtask

    // Let every pending read come back, then give in-flight writes time to land.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (reads_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all four registers back to back; valid stays high between them.
    task automatic program_regs(input logic [spbm_pkg::CFGD_W-1:0] bank_cnt,
                                input logic [spbm_pkg::CFGD_W-1:0] prg_sz,
                                input logic [spbm_pkg::CFGD_W-1:0] chr_ram,
                                input logic [spbm_pkg::CFGD_W-1:0] chr_sz);
        logic [spbm_pkg::CFGI_W-1:0] idx  [4];
        logic [spbm_pkg::CFGD_W-1:0] vals [4];
        idx  = '{spbm_pkg::CFG_PRG_BANK_COUNT, spbm_pkg::CFG_PRG_ROM_BYTES,
                 spbm_pkg::CFG_CHR_IS_RAM, spbm_pkg::CFG_CHR_ROM_BYTES};
        vals = '{bank_cnt, prg_sz, chr_ram, chr_sz};
        for (int k = 0; k < 4; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= vals[k];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass on the reset setting (one bank, 16 KiB ROM, pattern RAM).
        // The first word waits out the RAM clear on the handshake.
        send_access(spbm_pkg::CMD_CPU_RD, 16'h0000, 8'h00);   // below RAM: unmapped
        send_access(spbm_pkg::CMD_CPU_RD, 16'h5FFF, 8'hFF);
        send_access(spbm_pkg::CMD_CPU_RD, 16'h6000, 8'h00);   // cleared RAM reads zero
        send_access(spbm_pkg::CMD_CPU_WR, 16'h6000, 8'hFF);
        send_access(spbm_pkg::CMD_CPU_WR, 16'h7FFF, 8'h5A);
        send_access(spbm_pkg::CMD_CPU_RD, 16'h6000, 8'h00);
        send_access(spbm_pkg::CMD_CPU_RD, 16'h7FFF, 8'h00);
        send_access(spbm_pkg::CMD_CPU_WR, 16'h5FFF, 8'hFF);   // ignored write
        send_access(spbm_pkg::CMD_CPU_RD, 16'h8000, 8'h00);
        send_access(spbm_pkg::CMD_CPU_RD, 16'hBFFF, 8'h00);
        send_access(spbm_pkg::CMD_CPU_RD, 16'hC000, 8'h00);   // fixed last bank
        send_access(spbm_pkg::CMD_CPU_RD, 16'hFFFF, 8'h00);
        send_access(spbm_pkg::CMD_CPU_WR, 16'hFFFF, 8'hFF);   // bank select wraps by count
        send_access(spbm_pkg::CMD_CPU_RD, 16'hBFFF, 8'h00);
        send_access(spbm_pkg::CMD_CPU_WR, 16'h8000, 8'h00);
        send_access(spbm_pkg::CMD_PPU_RD, 16'h0000, 8'h00);
        send_access(spbm_pkg::CMD_PPU_WR, 16'h1FFF, 8'hA5);
        send_access(spbm_pkg::CMD_PPU_RD, 16'h1FFF, 8'h00);
        send_access(spbm_pkg::CMD_PPU_WR, 16'h2000, 8'hFF);   // past pattern space: ignored
        send_access(spbm_pkg::CMD_PPU_RD, 16'h2000, 8'h00);
        send_access(spbm_pkg::CMD_PPU_RD, 16'hFFFF, 8'h00);
        send_access(spbm_pkg::CMD_PPU_WR, 16'h0000, 8'h00);
        send_access(spbm_pkg::CMD_PPU_RD, 16'h0000, 8'h00);

        for (int ph = 1; ph <= N_PHASES; ph++) begin
            settle();
            case (ph)
                1: program_regs(23'd8, 23'd131072, 23'd0, 23'd8192);
                // zero bank count and zero ROM sizes
                2: program_regs(23'd0, 23'd0, 23'd0, 23'd0);
                // all ones: count past 256, ROM address overflows 22 bits
                3: program_regs(23'd511, 23'h7FFFFF, 23'd1, 23'h3FFF);
                4: program_regs(23'd256, 23'd4194304, 23'd0, 23'd1);
                // odd sizes exercise the real remainder path
                5: program_regs(23'd5, 23'd77777, 23'd1, 23'd3000);
                6: program_regs(23'd1, 23'd1, 23'd0, 23'd5000);
                default: program_regs(spbm_pkg::CFGD_W'($urandom_range(0, 511)),
                                      spbm_pkg::CFGD_W'($urandom_range(1, 23'h7FFFFF)),
                                      spbm_pkg::CFGD_W'($urandom_range(0, 1)),
                                      spbm_pkg::CFGD_W'($urandom_range(1, 14'h3FFF)));
            endcase
            in_gaps_on    <= (ph % 3 != 1);
            out_stalls_on <= (ph % 3 != 2);
            repeat (RANDOM_PER_PHASE) send_random();
        end

        settle();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/core/spbm_pkg.sv
rtl/core/spbm_ram.sv
rtl/core/switchable_prg_bank_mapper.sv
verif/mapper_check.sv
verif/testbench.sv
